// ----- rtl/u8sd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned PEND_W  = 2;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned OUT_TUSER_W = 3;

    // lead byte classification
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    // payload masks
    localparam logic [BYTE_W-1:0] LEAD2_PAYLOAD = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_PAYLOAD = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_PAYLOAD = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_PAYLOAD  = 8'h3F;

    // continuation bytes still expected after each lead
    localparam logic [PEND_W-1:0] PEND_IDLE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_LEAD2 = 2'd1;
    localparam logic [PEND_W-1:0] PEND_LEAD3 = 2'd2;
    localparam logic [PEND_W-1:0] PEND_LEAD4 = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              final_byte;
    } t_item;

    typedef struct packed {
        logic [POINT_W-1:0] code_point;
        logic               point_valid;
        logic               lead_rejected;
        logic               sequence_cut;
        logic               end_marker;
    } t_result;

endpackage

// ----- rtl/u8sd_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_in_stage
// Input register: holds one accepted byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module u8sd_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  u8sd_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_take,
    output u8sd_pkg::t_item o_item
);

    logic            r_valid;
    u8sd_pkg::t_item r_item;
    logic            n_valid;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/u8sd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_decode
// Decode logic and sequence state: pending count and code point accumulator.
// ----------------------------------------------------------------------------
module u8sd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  u8sd_pkg::t_item   i_item,
    output u8sd_pkg::t_result o_result
);

    logic [u8sd_pkg::PEND_W-1:0]  r_pending;
    logic [u8sd_pkg::POINT_W-1:0] r_accum;
    logic [u8sd_pkg::PEND_W-1:0]  n_pending;
    logic [u8sd_pkg::POINT_W-1:0] n_accum;
    logic [u8sd_pkg::BYTE_W-1:0]  w_byte;
    logic [u8sd_pkg::BYTE_W-1:0]  w_cont;
    logic [u8sd_pkg::POINT_W-1:0] w_shift;

    assign w_byte  = i_item.data_byte;
    assign w_cont  = w_byte & u8sd_pkg::CONT_PAYLOAD;
    assign w_shift = {r_accum[u8sd_pkg::POINT_W-7:0], w_cont[5:0]};

    always_comb begin
        n_pending = r_pending;
        n_accum   = r_accum;
        o_result  = '0;
        o_result.end_marker = i_item.final_byte;
        if (r_pending == u8sd_pkg::PEND_IDLE) begin
            if ((w_byte & u8sd_pkg::ASCII_MASK) == '0) begin
                o_result.code_point  = u8sd_pkg::POINT_W'(w_byte);
                o_result.point_valid = 1'b1;
            end else if ((w_byte & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_CODE) begin
                n_accum   = u8sd_pkg::POINT_W'(w_byte & u8sd_pkg::LEAD2_PAYLOAD);
                n_pending = u8sd_pkg::PEND_LEAD2;
            end else if ((w_byte & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_CODE) begin
                n_accum   = u8sd_pkg::POINT_W'(w_byte & u8sd_pkg::LEAD3_PAYLOAD);
                n_pending = u8sd_pkg::PEND_LEAD3;
            end else if ((w_byte & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_CODE) begin
                n_accum   = u8sd_pkg::POINT_W'(w_byte & u8sd_pkg::LEAD4_PAYLOAD);
                n_pending = u8sd_pkg::PEND_LEAD4;
            end else begin
                o_result.lead_rejected = 1'b1;
            end
        end else begin
            n_pending = r_pending - 1'b1;
            n_accum   = w_shift;
            if (n_pending == u8sd_pkg::PEND_IDLE) begin
                o_result.code_point  = w_shift;
                o_result.point_valid = 1'b1;
                n_accum              = '0;
            end
        end
        if (i_item.final_byte) begin
            o_result.sequence_cut = (n_pending != u8sd_pkg::PEND_IDLE);
            n_pending             = u8sd_pkg::PEND_IDLE;
            n_accum               = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= u8sd_pkg::PEND_IDLE;
            r_accum   <= '0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.final_byte |=> r_pending == u8sd_pkg::PEND_IDLE && r_accum == '0)
        else $error("state not cleared after end of string");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_pending) && $stable(r_accum))
        else $error("decode state changed without a transaction");

    a_emit_ends_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.point_valid && r_pending != u8sd_pkg::PEND_IDLE
        |=> r_pending == u8sd_pkg::PEND_IDLE)
        else $error("sequence still pending after code point emitted");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |-> $countones({o_result.point_valid, o_result.lead_rejected,
                               o_result.sequence_cut}) <= 1)
        else $error("more than one result flag set");

endmodule

// ----- rtl/u8sd_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_out_stage
// Result register: holds one decoded result until the downstream takes it.
// ----------------------------------------------------------------------------
module u8sd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  u8sd_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output u8sd_pkg::t_result o_result
);

    logic              r_valid;
    u8sd_pkg::t_result r_result;
    logic              n_valid;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- rtl/utf8_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream to code point stream, one result per input byte.
// Path: input register, then decode logic, then result register.
// Throughput: 1 byte per cycle while m_axis_tready stays high; the decode
// between the input register and the result register is combinational.
// Reset: synchronous active low; clears the valid flags of both stages and the sequence state.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [u8sd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
    input  logic                                s_axis_tlast,  // final_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [u8sd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [20:0] code_point, [23:21] 0
    output logic [u8sd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,  // [0] point_valid,
                                                               // [1] lead_rejected,
                                                               // [2] sequence_cut
    output logic                                m_axis_tlast   // end_marker
);

    u8sd_pkg::t_item   w_in_item;
    u8sd_pkg::t_item   w_stage_item;
    u8sd_pkg::t_result w_dec_result;
    u8sd_pkg::t_result w_out_result;
    logic              w_stage_valid;
    logic              w_out_free;
    logic              w_fire;

    assign w_in_item.data_byte  = s_axis_tdata[u8sd_pkg::BYTE_W-1:0];
    assign w_in_item.final_byte = s_axis_tlast;
    assign w_fire               = w_stage_valid && w_out_free;

    u8sd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_stage_valid),
        .i_take  (w_fire),
        .o_item  (w_stage_item)
    );

    u8sd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_stage_item),
        .o_result (w_dec_result)
    );

    u8sd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_dec_result),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_result)
    );

    assign m_axis_tdata = u8sd_pkg::OUT_TDATA_W'(w_out_result.code_point);
    assign m_axis_tuser = {w_out_result.sequence_cut, w_out_result.lead_rejected,
                           w_out_result.point_valid};
    assign m_axis_tlast = w_out_result.end_marker;

endmodule

// ----- tb/utf8_stream_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit_tb
// Self-checking bench for the UTF-8 stream decoder. A directed set covers
// every lead class, boundary bytes, invalid leads, overlong forms and strings
// cut short. Random strings of mostly well-formed characters with some noise
// and broken sequences follow. Both stream sides stall at random. Every
// result transaction is compared with a cycle-free model of the decoder.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit_tb;

    localparam int  RANDOM_BYTES = 1450;
    localparam real RUN_LIMIT_NS = 10_000_000.0;

    class utf8_point_scoreboard;
        logic [u8sd_pkg::PEND_W-1:0]  pend;
        logic [u8sd_pkg::POINT_W-1:0] accum;
        u8sd_pkg::t_result            expected_points[$];
        int                           errors;
        int                           bytes_seen;
        int                           points_seen;
        int                           rejects_seen;
        int                           cuts_seen;

        function new();
            pend         = u8sd_pkg::PEND_IDLE;
            accum        = '0;
            errors       = 0;
            bytes_seen   = 0;
            points_seen  = 0;
            rejects_seen = 0;
            cuts_seen    = 0;
        endfunction

        function void note_byte(logic [u8sd_pkg::BYTE_W-1:0] b, logic last);
            u8sd_pkg::t_result r;
            r            = '0;
            r.end_marker = last;
            if (pend == u8sd_pkg::PEND_IDLE) begin
                if ((b & u8sd_pkg::ASCII_MASK) == '0) begin
                    r.code_point  = {13'd0, b};
                    r.point_valid = 1'b1;
                end else if ((b & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_CODE) begin
                    accum = {13'd0, b & u8sd_pkg::LEAD2_PAYLOAD};
                    pend  = u8sd_pkg::PEND_LEAD2;
                end else if ((b & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_CODE) begin
                    accum = {13'd0, b & u8sd_pkg::LEAD3_PAYLOAD};
                    pend  = u8sd_pkg::PEND_LEAD3;
                end else if ((b & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_CODE) begin
                    accum = {13'd0, b & u8sd_pkg::LEAD4_PAYLOAD};
                    pend  = u8sd_pkg::PEND_LEAD4;
                end else begin
                    r.lead_rejected = 1'b1;
                end
            end else begin
                // continuation bits go in unchecked
                accum = (accum << 6) | {13'd0, b & u8sd_pkg::CONT_PAYLOAD};
                pend  = pend - 1'b1;
                if (pend == u8sd_pkg::PEND_IDLE) begin
                    r.code_point  = accum;
                    r.point_valid = 1'b1;
                    accum         = '0;
                end
            end
            if (last) begin
                if (pend != u8sd_pkg::PEND_IDLE) r.sequence_cut = 1'b1;
                pend  = u8sd_pkg::PEND_IDLE;
                accum = '0;
            end
            bytes_seen++;
            expected_points = {expected_points, r};
        endfunction

        function void check_point(u8sd_pkg::t_result got);
            u8sd_pkg::t_result exp_r;
            if (expected_points.size() == 0) begin
                $error("result transaction with nothing expected: tdata %0h", got.code_point);
                errors++;
                return;
            end
            exp_r = expected_points.pop_front();
            if (got.code_point !== exp_r.code_point) begin
                $error("code_point mismatch: expected %0h, actual %0h",
                       exp_r.code_point, got.code_point);
                errors++;
            end
            if (got.point_valid !== exp_r.point_valid) begin
                $error("point_valid mismatch: expected %0b, actual %0b",
                       exp_r.point_valid, got.point_valid);
                errors++;
            end
            if (got.lead_rejected !== exp_r.lead_rejected) begin
                $error("lead_rejected mismatch: expected %0b, actual %0b",
                       exp_r.lead_rejected, got.lead_rejected);
                errors++;
            end
            if (got.sequence_cut !== exp_r.sequence_cut) begin
                $error("sequence_cut mismatch: expected %0b, actual %0b",
                       exp_r.sequence_cut, got.sequence_cut);
                errors++;
            end
            if (got.end_marker !== exp_r.end_marker) begin
                $error("end_marker mismatch: expected %0b, actual %0b",
                       exp_r.end_marker, got.end_marker);
                errors++;
            end
            if (exp_r.point_valid)   points_seen++;
            if (exp_r.lead_rejected) rejects_seen++;
            if (exp_r.sequence_cut)  cuts_seen++;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [u8sd_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] data_byte
    logic                             s_axis_tlast;   // final_byte
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [u8sd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // [20:0] code_point, [23:21] 0
    logic [u8sd_pkg::OUT_TUSER_W-1:0] m_axis_tuser;   // [0] point_valid,
                                                      // [1] lead_rejected,
                                                      // [2] sequence_cut
    logic                             m_axis_tlast;   // end_marker

    utf8_point_scoreboard             points_sb;
    u8sd_pkg::t_result                seen_point;
    int                               stall_left;
    bit                               steady_flow;
    logic [u8sd_pkg::BYTE_W-1:0]      string_bytes[$];

    // {final_byte, data_byte}
    logic [8:0] directed_bytes [25] = '{
        9'h000, 9'h17F,                         // ascii extremes
        9'h0C2, 9'h0A9,                         // two-byte
        9'h0E2, 9'h082, 9'h0AC,                 // three-byte
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,         // four-byte, top of 21 bits
        9'h080, 9'h0FF, 9'h0F8,                 // invalid leads
        9'h0C0, 9'h080,                         // overlong
        9'h1E2,                                 // lead on last byte
        9'h0F0, 9'h09F, 9'h198,                 // unfinished at end
        9'h0DF, 9'h0FF,                         // 0xFF taken as continuation
        9'h0C3, 9'h041,                         // ascii taken as continuation
        9'h1C1                                  // two-byte lead on last byte
    };

    utf8_stream_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [u8sd_pkg::BYTE_W-1:0] cont_byte();
        // mostly proper 10xxxxxx, sometimes anything
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic void append_char();
        int sel;
        int len;
        int conts;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            string_bytes = {string_bytes, 8'($urandom_range(0, 127))};
            return;
        end
        if (sel < 85) begin
            string_bytes = {string_bytes, 8'($urandom_range(0, 255)) | 8'h80 | 8'h40};
        end else if (sel < 93) begin
            string_bytes = {string_bytes, 8'($urandom_range(0, 255))};
            return;
        end
        len = (sel < 50) ? 2 : (sel < 70) ? 3 : (sel < 85) ? 4 : $urandom_range(2, 4);
        case (len)
            2: begin
                if (sel >= 85)
                    string_bytes = {string_bytes,
                                    u8sd_pkg::LEAD2_CODE | 8'($urandom_range(0, 31))};
                else
                    string_bytes[$] = u8sd_pkg::LEAD2_CODE
                                    | (string_bytes[$] & u8sd_pkg::LEAD2_PAYLOAD);
            end
            3: begin
                if (sel >= 85)
                    string_bytes = {string_bytes,
                                    u8sd_pkg::LEAD3_CODE | 8'($urandom_range(0, 15))};
                else
                    string_bytes[$] = u8sd_pkg::LEAD3_CODE
                                    | (string_bytes[$] & u8sd_pkg::LEAD3_PAYLOAD);
            end
            default: begin
                if (sel >= 85)
                    string_bytes = {string_bytes,
                                    u8sd_pkg::LEAD4_CODE | 8'($urandom_range(0, 7))};
                else
                    string_bytes[$] = u8sd_pkg::LEAD4_CODE
                                    | (string_bytes[$] & u8sd_pkg::LEAD4_PAYLOAD);
            end
        endcase
        // broken sequences get fewer continuations than the lead asks for
        conts = (sel >= 93) ? $urandom_range(0, len - 2) : len - 1;
        for (int k = 0; k < conts; k++) string_bytes = {string_bytes, cont_byte()};
    endfunction

    task automatic send_byte(input logic [u8sd_pkg::BYTE_W-1:0] b, input logic last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        points_sb.note_byte(b, last);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_point.code_point    = m_axis_tdata[u8sd_pkg::POINT_W-1:0];
                seen_point.point_valid   = m_axis_tuser[0];
                seen_point.lead_rejected = m_axis_tuser[1];
                seen_point.sequence_cut  = m_axis_tuser[2];
                seen_point.end_marker    = m_axis_tlast;
                points_sb.check_point(seen_point);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left    <= pick_gap();
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int n_chars;
        int strings_sent;
        points_sb     = new();
        steady_flow   = 1'b0;
        strings_sent  = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

        while (points_sb.bytes_seen < RANDOM_BYTES + 25) begin
            if (strings_sent % 20 == 0) steady_flow = ($urandom_range(0, 3) == 0);
            n_chars = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 6);
            string_bytes.delete();
            for (int c = 0; c < n_chars; c++) append_char();
            foreach (string_bytes[i])
                send_byte(string_bytes[i], i == string_bytes.size() - 1);
            strings_sent++;
        end
        s_axis_tvalid <= 1'b0;
        steady_flow   = 1'b0;

        while (points_sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes in %0d random strings plus a directed set",
                 points_sb.bytes_seen, strings_sent);
        $display("checked %0d code points, %0d rejected leads, %0d cut sequences",
                 points_sb.points_seen, points_sb.rejects_seen, points_sb.cuts_seen);
        if (points_sb.errors == 0 && points_sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- utf8_stream_decoder_unit.f -----
rtl/u8sd_pkg.sv
rtl/u8sd_in_stage.sv
rtl/u8sd_decode.sv
rtl/u8sd_out_stage.sv
rtl/utf8_stream_decoder_unit.sv
tb/utf8_stream_decoder_unit_tb.sv
